@@ design/flcs_pkg.sv @@
// ----------------------------------------------------------------------------
// flcs_pkg
// Shared types, command codes and character helpers for the filtered LCS
// similarity block.
// ----------------------------------------------------------------------------
`default_nettype none

package flcs_pkg;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int SCORE_W = 7;

    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    localparam logic [SYM_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [SYM_W-1:0] CHAR_QUESTION = 8'h3F;
    localparam logic [SYM_W-1:0] CHAR_NEWLINE  = 8'h0A;

    // one second-string byte travelling along the cell row
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
    } wave_t;

    function automatic logic is_blank(input logic [SYM_W-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_QUESTION) || (c == CHAR_NEWLINE);
    endfunction

endpackage

`default_nettype wire

@@ design/flcs_cell.sv @@
// ----------------------------------------------------------------------------
// flcs_cell
// One position of the stored first string: its byte, its keep flag and its
// entry of the LCS column. Updates when a second-string byte passes through.
// ----------------------------------------------------------------------------
`default_nettype none

module flcs_cell
    import flcs_pkg::*;
#(
    parameter int SW = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             clr,
    input  wire logic             wr_en,
    input  wire logic [SYM_W-1:0] wr_sym,
    input  wire logic             prev_blank,   // left neighbor blank or string start
    input  wire logic             next_blank,   // right neighbor blank or string end
    output logic                  occ_o,
    output logic                  blank_o,
    input  wire wave_t            in_wave,
    input  wire logic [SW-1:0]    in_left,
    input  wire logic [SW-1:0]    in_diag,
    output wave_t                 out_wave,
    output logic [SW-1:0]         out_left,
    output logic [SW-1:0]         out_diag,
    output logic [SW-1:0]         score_o
);

    logic             occ_reg;
    logic [SYM_W-1:0] char_reg;
    logic [SW-1:0]    score_reg;
    logic [SW-1:0]    score_next;
    wave_t            wave_reg;
    logic [SW-1:0]    left_reg;
    logic [SW-1:0]    diag_reg;
    logic             keep;

    assign blank_o = is_blank(char_reg);
    assign occ_o   = occ_reg;
    assign keep    = occ_reg && !blank_o && !(prev_blank && next_blank);

    always_comb begin
        if (!keep) begin
            score_next = in_left;
        end else if (char_reg == in_wave.sym) begin
            score_next = in_diag + SW'(1);
        end else if (in_left > score_reg) begin
            score_next = in_left;
        end else begin
            score_next = score_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            occ_reg   <= 1'b0;
            score_reg <= '0;
            wave_reg  <= '0;
        end else begin
            if (wr_en) begin
                occ_reg <= 1'b1;
            end
            if (in_wave.valid) begin
                score_reg <= score_next;
            end
            wave_reg <= in_wave;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_reg <= wr_sym;
        end
        left_reg     <= score_next;
        diag_reg     <= score_reg;
    end

    assign out_wave = wave_reg;
    assign out_left = left_reg;
    assign out_diag = diag_reg;
    assign score_o  = score_reg;

endmodule

`default_nettype wire

@@ design/filtered_lcs_similarity.sv @@
// ----------------------------------------------------------------------------
// filtered_lcs_similarity
// LCS length of two filtered byte strings. The first string is stored in a
// row of cells; second-string bytes sweep along the row as a wavefront.
// ----------------------------------------------------------------------------
//  channel | ports                              | dir | content
//  --------+------------------------------------+-----+---------------------------
//  s_      | s_valid s_ready s_cmd s_symbol     | in  | command and byte request
//  m_      | m_valid m_ready m_score m_overflow | out | score of one string pair
//
//  A new first- or second-string request is taken every cycle while the input
//  is open. An end request blocks input while the last byte crosses the cell
//  row, then the score is registered and the row is cleared. A result waiting
//  on m_ready stalls only the completion of the next drain, which keeps the
//  input closed. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_lcs_similarity
    import flcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CMD_W-1:0]   s_cmd,
    input  wire logic [SYM_W-1:0]   s_symbol,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [SCORE_W-1:0]      m_score,
    output logic                    m_overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int SW    = LEN_W;
    localparam int CNT_W = $clog2(MAX_LEN + 2);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SYM_W-1:0] pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             bpb_reg, bpb_next;
    logic             trunc_reg, trunc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    wave_t            inj_reg, inj_next;
    logic             m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0] m_score_reg, m_score_next;
    logic             m_ovf_reg, m_ovf_next;

    logic             accept;
    logic             judge;
    logic             right_blank;
    logic             drop;
    logic             wr_go;
    logic             clr;
    logic [IDX_W-1:0] wr_idx;
    logic [SW-1:0]    score_last;
    logic [SW+SCORE_W-1:0] score_ext;

    wave_t            wave [0:MAX_LEN];
    logic [SW-1:0]    left [0:MAX_LEN];
    logic [SW-1:0]    diag [0:MAX_LEN];
    logic [SW-1:0]    score [0:MAX_LEN-1];
    logic             occ  [0:MAX_LEN-1];
    logic             blank[0:MAX_LEN-1];

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign right_blank = (s_cmd == CMD_END) ? 1'b1 : is_blank(s_symbol);
    assign judge       = accept && pend_valid_reg && (s_cmd == CMD_SECOND || s_cmd == CMD_END);
    assign drop        = is_blank(pend_reg) || (bpb_reg && right_blank);
    assign wr_go       = accept && (s_cmd == CMD_FIRST) && !pend_valid_reg
                         && (len_reg < LEN_W'(MAX_LEN));
    assign wr_idx      = len_reg[IDX_W-1:0];
    assign score_last  = score[MAX_LEN-1];
    assign score_ext   = {{SCORE_W{1'b0}}, score_last};

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        bpb_next        = bpb_reg;
        trunc_next      = trunc_reg;
        cnt_next        = cnt_reg;
        m_score_next    = m_score_reg;
        m_ovf_next      = m_ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        clr             = 1'b0;
        inj_next.valid  = judge && !drop;
        inj_next.sym    = pend_reg;

        if (judge) begin
            bpb_next = is_blank(pend_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_FIRST: begin
                            if (wr_go) begin
                                len_next = len_reg + LEN_W'(1);
                            end else if (!pend_valid_reg) begin
                                trunc_next = 1'b1;
                            end
                        end
                        CMD_SECOND: begin
                            pend_next       = s_symbol;
                            pend_valid_next = 1'b1;
                        end
                        CMD_END: begin
                            state_next = ST_DRAIN;
                            cnt_next   = CNT_W'(MAX_LEN + 1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_score_next    = score_ext[SCORE_W-1:0];
                    m_ovf_next      = trunc_reg;
                    clr             = 1'b1;
                    len_next        = '0;
                    pend_next       = '0;
                    pend_valid_next = 1'b0;
                    bpb_next        = 1'b1;
                    trunc_next      = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            bpb_reg        <= 1'b1;
            trunc_reg      <= 1'b0;
            cnt_reg        <= '0;
            inj_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            bpb_reg        <= bpb_next;
            trunc_reg      <= trunc_next;
            cnt_reg        <= cnt_next;
            inj_reg        <= inj_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_score_reg <= m_score_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign wave[0] = inj_reg;
    assign left[0] = '0;
    assign diag[0] = '0;

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        logic prev_b;
        logic next_b;

        if (i == 0) begin : g_first
            assign prev_b = 1'b1;
        end else begin : g_mid_l
            assign prev_b = blank[i-1];
        end

        if (i == MAX_LEN - 1) begin : g_last
            assign next_b = 1'b1;
        end else begin : g_mid_r
            assign next_b = !occ[i+1] || blank[i+1];
        end

        flcs_cell #(
            .SW(SW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .clr        (clr),
            .wr_en      (wr_go && (wr_idx == IDX_W'(i))),
            .wr_sym     (s_symbol),
            .prev_blank (prev_b),
            .next_blank (next_b),
            .occ_o      (occ[i]),
            .blank_o    (blank[i]),
            .in_wave    (wave[i]),
            .in_left    (left[i]),
            .in_diag    (diag[i]),
            .out_wave   (wave[i+1]),
            .out_left   (left[i+1]),
            .out_diag   (diag[i+1]),
            .score_o    (score[i])
        );
    end

    assign m_valid    = m_valid_reg;
    assign m_score    = m_score_reg;
    assign m_overflow = m_ovf_reg;

endmodule

`default_nettype wire

@@ design/flcs_checker.sv @@
// ----------------------------------------------------------------------------
// flcs_checker
// Port-level checks for the filtered LCS similarity block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module flcs_checker
    import flcs_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [CMD_W-1:0]   s_cmd,
    input wire logic [SYM_W-1:0]   s_symbol,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [SCORE_W-1:0] m_score,
    input wire logic               m_overflow
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score) && $stable(m_overflow))
        else $error("result changed while stalled");

    // an end request closes the input while the row drains
    a_end_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_END |=> !s_ready)
        else $error("input open right after end request");

    // only an end request closes the input
    a_close_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_cmd == CMD_END))
        else $error("input closed without end request");

    // a new result appears exactly when the input reopens
    a_result_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $rose(s_ready))
        else $error("result not tied to drain completion");

    // score never exceeds MAX_LEN (checked when MAX_LEN is below 128)
    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && MAX_LEN < 128 |-> 32'(m_score) <= MAX_LEN)
        else $error("score above stored length");

endmodule

bind filtered_lcs_similarity flcs_checker #(.MAX_LEN(MAX_LEN)) u_flcs_checker (.*);

`default_nettype wire
